[rtl/dop_pkg.sv]
// Package for the DHCP option parser: item and record types, parse phases,
// option tags and status codes. Depends on nothing.
`default_nettype none

package dop_pkg;

  // Parse phase of the vendor area walk
  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_TAG    = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // Kind of a result word
  typedef enum logic [1:0] {
    KIND_HOST    = 2'd0,
    KIND_ROOT    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // Summary status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_COOKIE = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  // Option tags that the parser acts on
  localparam logic [7:0] TAG_PAD     = 8'd0;
  localparam logic [7:0] TAG_MASK    = 8'd1;
  localparam logic [7:0] TAG_ROUTER  = 8'd3;
  localparam logic [7:0] TAG_HOST    = 8'd12;
  localparam logic [7:0] TAG_SWAP    = 8'd16;
  localparam logic [7:0] TAG_ROOT    = 8'd17;
  localparam logic [7:0] TAG_MSGTYPE = 8'd53;
  localparam logic [7:0] TAG_SRV_ID  = 8'd54;
  localparam logic [7:0] TAG_END     = 8'd255;

  localparam logic [7:0] MSG_TYPE_RESET = 8'd2;

  // Magic cookie 99.130.83.99
  localparam logic [7:0] COOKIE [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

  typedef struct packed {
    logic [7:0] vend_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  text_byte;
    logic [1:0]  status;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_addr;
    logic [31:0] swap_server_addr;
    logic [31:0] server_id_addr;
    logic        dhcp_ok;
    logic        final_flag;
  } out_item_t;

  // One queue record: the results caused by one input byte
  typedef struct packed {
    logic        has_text;
    kind_e       text_kind;
    logic [7:0]  text_byte;
    logic        has_sum;
    status_e     status;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [31:0] swap;
    logic [31:0] server;
    logic        ok;
  } rec_t;

endpackage

`default_nettype wire

[rtl/dhcp_option_parser.sv]
// Top level of the DHCP option parser: front end, record queue and result
// emitter. Depends on dop_pkg, dop_front, dop_queue and dop_back.
`default_nettype none

// The block takes the vendor area of a BOOTP reply one byte per word, checks
// the magic cookie and walks the options to the end tag. Host name and root
// path bytes come out as one word each; the word that carries the last byte
// of the area also yields a summary word with the status, captured addresses
// and the message type check. A byte is accepted in every cycle while the
// record queue has room; the parse state updates in that same cycle. A byte
// with results becomes one queue record, emitted one word per cycle while
// the output is ready, so a string byte that is also the last byte gives
// two words. The queue holds QueueDepth records, so short output stalls do
// not stop the input. Write the expected message type only between areas.
module dhcp_option_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire dop_pkg::in_item_t  in_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      dop_pkg::out_item_t out_item_o
);

  logic          in_fire;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  dop_pkg::rec_t push_rec;
  dop_pkg::rec_t pop_rec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign in_fire     = in_valid_i && !full;

  // Parse bytes and classify their results
  dop_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (in_fire),
    .item_i     (in_item_i),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  // Decouple parsing from output stalls
  dop_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .pop_i     (pop),
    .pop_rec_o (pop_rec),
    .full_o    (full),
    .empty_o   (empty)
  );

  // Emit result words
  dop_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .rec_i      (pop_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

[rtl/dop_front.sv]
// Front end of the DHCP option parser: accepts vendor bytes, walks the
// cookie and options, and produces one record per byte that has results.
// Depends on dop_pkg.
`default_nettype none

module dop_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             fire_i,
  input  wire dop_pkg::in_item_t item_i,
  output      logic             push_o,
  output      dop_pkg::rec_t    rec_o
);

  logic [7:0]       exp_type_q;
  dop_pkg::phase_e  phase_q, phase_n, phase_d;
  logic [1:0]       cidx_q, cidx_n, cidx_d;
  logic             cmatch_q, cmatch_n, cmatch_d;
  logic [7:0]       tag_q, tag_n, tag_d;
  logic [7:0]       left_q, left_n, left_d;
  logic [1:0]       vidx_q, vidx_n, vidx_d;
  logic [31:0]      acc_q, acc_n, acc_d;
  logic [31:0]      mask_q, mask_n, mask_d;
  logic [31:0]      gw_q, gw_n, gw_d;
  logic [31:0]      swap_q, swap_n, swap_d;
  logic [31:0]      srv_q, srv_n, srv_d;
  logic             ok_q, ok_n, ok_d;
  dop_pkg::status_e status_q, status_n, status_fin, status_d;
  logic [7:0]       b;
  logic             is_addr_tag;

  assign b = item_i.vend_byte;
  assign is_addr_tag = (tag_q == dop_pkg::TAG_MASK) || (tag_q == dop_pkg::TAG_ROUTER) ||
                       (tag_q == dop_pkg::TAG_SWAP) || (tag_q == dop_pkg::TAG_SRV_ID);

  // Hold the expected message type
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= dop_pkg::MSG_TYPE_RESET;
    end else if (cfg_valid_i) begin
      exp_type_q <= cfg_data_i;
    end
  end

  // Next state after taking this byte, before the end-of-area clear
  always_comb begin
    phase_n  = phase_q;
    cidx_n   = cidx_q;
    cmatch_n = cmatch_q;
    tag_n    = tag_q;
    left_n   = left_q;
    vidx_n   = vidx_q;
    acc_n    = acc_q;
    mask_n   = mask_q;
    gw_n     = gw_q;
    swap_n   = swap_q;
    srv_n    = srv_q;
    ok_n     = ok_q;
    status_n = status_q;
    case (phase_q)
      dop_pkg::PH_COOKIE: begin
        if (b != dop_pkg::COOKIE[cidx_q]) begin
          cmatch_n = 1'b0;
        end
        if (cidx_q == 2'd3) begin
          if (cmatch_n) begin
            phase_n = dop_pkg::PH_TAG;
          end else begin
            status_n = dop_pkg::ST_NO_COOKIE;
            phase_n  = dop_pkg::PH_DONE;
          end
        end else begin
          cidx_n = cidx_q + 2'd1;
        end
      end
      dop_pkg::PH_TAG: begin
        if (b == dop_pkg::TAG_END) begin
          phase_n = dop_pkg::PH_DONE;
        end else if (b != dop_pkg::TAG_PAD) begin
          tag_n   = b;
          phase_n = dop_pkg::PH_LEN;
        end
      end
      dop_pkg::PH_LEN: begin
        left_n  = b;
        vidx_n  = 2'd0;
        acc_n   = '0;
        phase_n = (b == 8'd0) ? dop_pkg::PH_TAG : dop_pkg::PH_VALUE;
      end
      dop_pkg::PH_VALUE: begin
        if ((tag_q == dop_pkg::TAG_MSGTYPE) && (b != exp_type_q)) begin
          // Reject the area on a message type mismatch
          status_n = dop_pkg::ST_MISMATCH;
          ok_n     = 1'b0;
          phase_n  = dop_pkg::PH_DONE;
        end else begin
          if (tag_q == dop_pkg::TAG_MSGTYPE) begin
            ok_n  = 1'b1;
            tag_n = '0;
          end else if (is_addr_tag) begin
            acc_n = {acc_q[23:0], b};
            if (vidx_q == 2'd3) begin
              if (tag_q == dop_pkg::TAG_MASK) begin
                mask_n = acc_n;
              end else if (tag_q == dop_pkg::TAG_ROUTER) begin
                gw_n = acc_n;
              end else if (tag_q == dop_pkg::TAG_SWAP) begin
                swap_n = acc_n;
              end else begin
                srv_n = acc_n;
              end
              tag_n = '0;
            end else begin
              vidx_n = vidx_q + 2'd1;
            end
          end
          left_n = left_q - 8'd1;
          if (left_n == 8'd0) begin
            phase_n = dop_pkg::PH_TAG;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Final status on the last byte, and clear everything after the summary
  always_comb begin
    status_fin = status_n;
    if (status_n == dop_pkg::ST_OK) begin
      if (phase_n == dop_pkg::PH_COOKIE) begin
        status_fin = dop_pkg::ST_NO_COOKIE;
      end else if (phase_n == dop_pkg::PH_LEN || phase_n == dop_pkg::PH_VALUE) begin
        status_fin = dop_pkg::ST_TRUNC;
      end
    end
    if (item_i.last_byte) begin
      phase_d  = dop_pkg::PH_COOKIE;
      cidx_d   = 2'd0;
      cmatch_d = 1'b1;
      tag_d    = '0;
      left_d   = '0;
      vidx_d   = 2'd0;
      acc_d    = '0;
      mask_d   = '0;
      gw_d     = '0;
      swap_d   = '0;
      srv_d    = '0;
      ok_d     = 1'b0;
      status_d = dop_pkg::ST_OK;
    end else begin
      phase_d  = phase_n;
      cidx_d   = cidx_n;
      cmatch_d = cmatch_n;
      tag_d    = tag_n;
      left_d   = left_n;
      vidx_d   = vidx_n;
      acc_d    = acc_n;
      mask_d   = mask_n;
      gw_d     = gw_n;
      swap_d   = swap_n;
      srv_d    = srv_n;
      ok_d     = ok_n;
      status_d = status_n;
    end
  end

  // Build the record for this byte
  always_comb begin
    rec_o.has_text  = (phase_q == dop_pkg::PH_VALUE) &&
                      ((tag_q == dop_pkg::TAG_HOST) || (tag_q == dop_pkg::TAG_ROOT));
    rec_o.text_kind = (tag_q == dop_pkg::TAG_HOST) ? dop_pkg::KIND_HOST
                                                    : dop_pkg::KIND_ROOT;
    rec_o.text_byte = b;
    rec_o.has_sum   = item_i.last_byte;
    rec_o.status    = status_fin;
    rec_o.mask      = mask_n;
    rec_o.gateway   = gw_n;
    rec_o.swap      = swap_n;
    rec_o.server    = srv_n;
    rec_o.ok        = ok_n;
    push_o          = fire_i && (rec_o.has_text || rec_o.has_sum);
  end

  // Advance the parse state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dop_pkg::PH_COOKIE;
      cidx_q   <= 2'd0;
      cmatch_q <= 1'b1;
      tag_q    <= '0;
      left_q   <= '0;
      vidx_q   <= 2'd0;
      acc_q    <= '0;
      mask_q   <= '0;
      gw_q     <= '0;
      swap_q   <= '0;
      srv_q    <= '0;
      ok_q     <= 1'b0;
      status_q <= dop_pkg::ST_OK;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      cidx_q   <= cidx_d;
      cmatch_q <= cmatch_d;
      tag_q    <= tag_d;
      left_q   <= left_d;
      vidx_q   <= vidx_d;
      acc_q    <= acc_d;
      mask_q   <= mask_d;
      gw_q     <= gw_d;
      swap_q   <= swap_d;
      srv_q    <= srv_d;
      ok_q     <= ok_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

[rtl/dop_queue.sv]
// Record queue between the front end and the result emitter of the DHCP
// option parser. Depends on dop_pkg.
`default_nettype none

module dop_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dop_pkg::rec_t push_rec_i,
  input  wire logic          pop_i,
  output      dop_pkg::rec_t pop_rec_o,
  output      logic          full_o,
  output      logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dop_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

`default_nettype wire

[rtl/dop_back.sv]
// Result emitter of the DHCP option parser: pops records and drives the
// output register, a text word first and then the summary. Depends on dop_pkg.
`default_nettype none

module dop_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire dop_pkg::rec_t rec_i,
  output      logic          pop_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      dop_pkg::out_item_t out_item_o
);

  logic               out_valid_q, out_valid_d;
  dop_pkg::out_item_t out_q, out_d;
  logic               pend_q, pend_d;
  dop_pkg::out_item_t sum_q, sum_d;
  dop_pkg::out_item_t rec_text, rec_sum;
  logic               slot_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Unpack the head record into its two possible words
  always_comb begin
    rec_text             = '0;
    rec_text.result_kind = rec_i.text_kind;
    rec_text.text_byte   = rec_i.text_byte;

    rec_sum                  = '0;
    rec_sum.result_kind      = dop_pkg::KIND_SUMMARY;
    rec_sum.status           = rec_i.status;
    rec_sum.subnet_mask      = rec_i.mask;
    rec_sum.gateway_addr     = rec_i.gateway;
    rec_sum.swap_server_addr = rec_i.swap;
    rec_sum.server_id_addr   = rec_i.server;
    rec_sum.dhcp_ok          = rec_i.ok;
    rec_sum.final_flag       = 1'b1;
  end

  // Load the output register: pending summary first, then the next record
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    sum_d       = sum_q;
    pop_o       = 1'b0;
    if (slot_free) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_d       = sum_q;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        if (rec_i.has_text) begin
          out_d  = rec_text;
          pend_d = rec_i.has_sum;
          sum_d  = rec_sum;
        end else begin
          out_d = rec_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sum_q <= sum_d;
  end

endmodule

`default_nettype wire
